// ===== rtl/core/multi_waveform_oscillator_sample_core_defines.svh =====
// Assertion macros for the oscillator sample core.
// Taken in by the top level only; each macro samples on clk and is off during rst.
`ifndef MULTI_WAVEFORM_OSCILLATOR_SAMPLE_CORE_DEFINES_SVH
`define MULTI_WAVEFORM_OSCILLATOR_SAMPLE_CORE_DEFINES_SVH

// condition holds on every edge
`define MWO_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent on the same edge
`define MWO_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/mwo_pkg.sv =====
// Shared types and constants for the oscillator sample core.
// No dependencies; compiled first.
package mwo_pkg;

  localparam int PHASE_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int MODE_W   = 3;
  localparam int WAVE_W   = 2;
  localparam int VOL_W    = 7;
  localparam int PITCH_W  = 6;
  localparam int MAG_W    = 15;   // quarter-wave magnitude, 0..32767
  localparam int PROD_W   = 24;   // sample x volume
  localparam int PMAG_W   = 23;   // magnitude of that product

  localparam int PITCH_STEPS = 49;
  localparam logic [PITCH_W-1:0] PITCH_MAX = PITCH_W'(PITCH_STEPS - 1);
  localparam logic [PITCH_W-1:0] PITCH_RESET =
    (24 < PITCH_STEPS - 1) ? PITCH_W'(24) : PITCH_W'(PITCH_STEPS - 1);

  localparam logic [VOL_W-1:0] MAX_GAIN   = 7'd100;
  localparam logic [VOL_W-1:0] RESET_GAIN = 7'd10;
  localparam logic [VOL_W-1:0] GAIN_STEP  = 7'd2;

  localparam logic [PHASE_W-1:0] PHASE_HALF = 16'h8000;
  localparam logic [PHASE_W-1:0] PHASE_QTR  = 16'h4000;
  localparam logic [PHASE_W-1:0] PHASE_3QTR = 16'hC000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;

  // floor(m / 100) == (m * RECIP_100) >> RECIP_SHIFT for m below about 6.1e6
  localparam int RECIP_SHIFT = 29;
  localparam logic [PMAG_W-1:0] RECIP_100 = 23'd5368710;

  // quarter-wave polynomial coefficients (Q16)
  localparam logic [15:0] POLY_A = 16'd42048;
  localparam logic [12:0] POLY_B = 13'd4640;
  localparam logic [16:0] POLY_C = 17'd102944;
  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam logic [32:0] ROUND_HALF = 33'd32768;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE     = 3'd0,
    MODE_WAVE_NEXT  = 3'd1,
    MODE_WAVE_PREV  = 3'd2,
    MODE_PITCH_UP   = 3'd3,
    MODE_PITCH_DOWN = 3'd4,
    MODE_VOL_UP     = 3'd5,
    MODE_VOL_DOWN   = 3'd6
  } mode_t;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_t;

  localparam wave_t RESET_WAVE = WAVE_SQUARE;

  typedef enum logic {
    ST_FILL,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PHASE_W-1:0] phase;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [WAVE_W-1:0]          wave_now;
    logic [VOL_W-1:0]           volume_now;
    logic [PITCH_W-1:0]         pitch_step;
  } out_t;

  typedef struct packed {
    logic wr_en;
    logic done;
  } fill_stat_t;

endpackage

// ===== rtl/core/mwo_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per handshake.
// Payload type is set at instantiation; no other dependencies.
interface mwo_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mwo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mwo_sine_fill.sv =====
// Post-reset fill of the quarter-wave sine table: six-stage polynomial pipeline.
// Depends on mwo_pkg; drives the write port of the table RAM.
module mwo_sine_fill #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  output mwo_pkg::fill_stat_t           stat,
  output logic [SINE_ADDR_BITS-2:0]     wr_addr,
  output logic [mwo_pkg::MAG_W-1:0]     wr_data
);
  import mwo_pkg::*;

  localparam int AW = SINE_ADDR_BITS - 1;
  localparam int XS = 18 - SINE_ADDR_BITS;
  localparam logic [AW-1:0] LAST = AW'(1) << (SINE_ADDR_BITS - 2);

  logic [AW-1:0] cnt;
  logic          issuing;
  logic [6:1]    vld;
  logic [AW-1:0] ra [1:6];
  logic          done;

  logic [16:0] x1, xb, xc, xd;
  logic [16:0] x2b, x2c;
  logic [15:0] t1c;
  logic [16:0] t2d;
  logic [16:0] ye;
  logic [MAG_W-1:0] fq;

  logic [33:0] p_b;
  logic [29:0] p_c;
  logic [32:0] p_d;
  logic [33:0] p_e;
  logic [32:0] p_f;

  assign p_b = {17'b0, x1} * {17'b0, x1};
  assign p_c = {13'b0, x2b} * {17'b0, POLY_B};
  assign p_d = {16'b0, x2c} * {17'b0, t1c};
  assign p_e = {17'b0, xd} * {17'b0, t2d};
  assign p_f = {16'b0, ye} * {18'b0, FULL_SCALE} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      issuing <= 1'b1;
      vld     <= '0;
      done    <= 1'b0;
    end else begin
      vld <= {vld[5:1], issuing};
      if (issuing) begin
        if (cnt == LAST) begin
          issuing <= 1'b0;
        end else begin
          cnt <= cnt + AW'(1);
        end
      end
      if (vld[6] && ra[6] == LAST) begin
        done <= 1'b1;
      end
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    x1    <= {cnt, {XS{1'b0}}};
    ra[1] <= cnt;
    // x^2
    x2b   <= p_b[32:16];
    xb    <= x1;
    ra[2] <= ra[1];
    // first Horner term
    t1c   <= POLY_A - {2'b0, p_c[29:16]};
    x2c   <= x2b;
    xc    <= xb;
    ra[3] <= ra[2];
    // second Horner term
    t2d   <= POLY_C - p_d[32:16];
    xd    <= xc;
    ra[4] <= ra[3];
    // y = x * t
    ye    <= p_e[32:16];
    ra[5] <= ra[4];
    // scale to 15-bit full scale with rounding
    fq    <= p_f[30:16];
    ra[6] <= ra[5];
  end

  assign stat.wr_en = vld[6];
  assign stat.done  = done;
  assign wr_addr    = ra[6];
  assign wr_data    = fq;

endmodule

// ===== rtl/core/multi_waveform_oscillator_sample_core.sv =====
// Multi-waveform oscillator sample core: top level.
// Depends on mwo_pkg, mwo_stream_if, mwo_ram, mwo_sine_fill and the defines header.
//
//   Channel | Dir | Payload                                  | Handshake
//   --------+-----+------------------------------------------+------------
//   req     | in  | mode[2:0], phase[15:0]                   | valid/ready
//   rsp     | out | sample, wave_now, volume_now, pitch_step | valid/ready
//
// One item per cycle sustained while rsp is ready. The table RAM is read at the accepting
// edge, then come the volume multiply, the reciprocal multiply for /100 and the output
// register.
// After rst the quarter-wave table RAM is filled by a six-stage pipeline:
// 2^(SINE_ADDR_BITS-2)+1 writes, with req.ready held low until the fill is done.
// Each stage advances when the stage after it is empty or moving, so an item is
// taken while a finished result waits on rsp; a full stall of rsp backs up to req.
`include "multi_waveform_oscillator_sample_core_defines.svh"

module multi_waveform_oscillator_sample_core #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  mwo_stream_if.sink   req,
  mwo_stream_if.source rsp
);
  import mwo_pkg::*;

  localparam int ROM_AW = SINE_ADDR_BITS - 1;
  localparam int ROM_DEPTH = (1 << (SINE_ADDR_BITS - 2)) + 1;
  localparam logic [ROM_AW-1:0] SINE_Q = ROM_AW'(1) << (SINE_ADDR_BITS - 2);

  typedef struct packed {
    logic [WAVE_W-1:0]  wave;
    logic [VOL_W-1:0]   vol;
    logic [PITCH_W-1:0] pitch;
  } rpt_t;

  // ---------------------------------------------------------------- control
  state_t state, state_next;
  logic   run_en;

  fill_stat_t           fill_stat;
  logic [ROM_AW-1:0]    fill_addr;
  logic [MAG_W-1:0]     fill_data;

  wave_t              wave_sel, wave_next;
  logic [VOL_W-1:0]   gain_pct, gain_next;
  logic [PITCH_W-1:0] pitch_idx, pitch_next;
  logic [VOL_W:0]     gain_up;
  logic               is_sample;
  logic               accept;

  // ---------------------------------------------------------------- pipeline
  logic v1, v2, v3, o_vld;
  logic rdy1, rdy2, rdy3, rdy_o;

  logic [PHASE_W-1:0]       s1_phase;
  wave_t                    s1_wave;
  logic [VOL_W-1:0]         s1_gain;
  rpt_t                     s1_rpt;

  logic signed [PROD_W-1:0] s2_prod;
  rpt_t                     s2_rpt;

  logic [SAMPLE_W-1:0]      s3_q;
  logic                     s3_neg;
  rpt_t                     s3_rpt;

  out_t                     o_item;

  logic [SINE_ADDR_BITS-3:0] sin_r;
  logic [ROM_AW-1:0]         rom_raddr;
  logic [MAG_W-1:0]          rom_rdata;

  logic [SAMPLE_W-1:0]       w_val;
  logic [SAMPLE_W-1:0]       sin_val;
  logic signed [PROD_W-1:0]  prod_next;
  logic [PMAG_W-1:0]         pmag;
  logic [2*PMAG_W-1:0]       quot_full;

  // ---------------------------------------------------------------- state machine
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: if (fill_stat.done) state_next = ST_RUN;
      ST_RUN:  state_next = ST_RUN;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_FILL: run_en = 1'b0;
      ST_RUN:  run_en = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- sine table
  mwo_sine_fill #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .stat    (fill_stat),
    .wr_addr (fill_addr),
    .wr_data (fill_data)
  );

  // quarter-wave index: mirror on odd quadrants, sign from the top phase bit
  assign sin_r     = req.payload.phase[13 -: (SINE_ADDR_BITS - 2)];
  assign rom_raddr = req.payload.phase[14] ? (SINE_Q - {1'b0, sin_r}) : {1'b0, sin_r};

  mwo_ram #(
    .WIDTH (MAG_W),
    .DEPTH (ROM_DEPTH)
  ) u_sine_ram (
    .clk   (clk),
    .we    (fill_stat.wr_en),
    .waddr (fill_addr),
    .wdata (fill_data),
    .re    (rdy1),
    .raddr (rom_raddr),
    .rdata (rom_rdata)
  );

  // ---------------------------------------------------------------- handshake
  // each stage moves when the one after it is empty or moving
  assign rdy_o  = !o_vld || rsp.ready;
  assign rdy3   = !v3 || rdy_o;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;
  assign req.ready = run_en && rdy1;
  assign accept = req.valid && req.ready;

  // ---------------------------------------------------------------- settings update
  assign gain_up = {1'b0, gain_pct} + {1'b0, GAIN_STEP};

  always_comb begin
    wave_next  = wave_sel;
    gain_next  = gain_pct;
    pitch_next = pitch_idx;
    is_sample  = 1'b0;
    unique case (mode_t'(req.payload.mode))
      MODE_SAMPLE:     is_sample = 1'b1;
      MODE_WAVE_NEXT:  wave_next = wave_t'(wave_sel + 2'd1);
      MODE_WAVE_PREV:  wave_next = wave_t'(wave_sel - 2'd1);
      MODE_PITCH_UP:   pitch_next = (pitch_idx < PITCH_MAX) ? pitch_idx + 6'd1 : PITCH_MAX;
      MODE_PITCH_DOWN: pitch_next = (pitch_idx != '0) ? pitch_idx - 6'd1 : pitch_idx;
      MODE_VOL_UP:
        gain_next = (gain_up > {1'b0, MAX_GAIN}) ? MAX_GAIN : gain_up[VOL_W-1:0];
      MODE_VOL_DOWN:
        gain_next = (gain_pct < GAIN_STEP) ? '0 : gain_pct - GAIN_STEP;
      default: ;  // unused code: no change, sample zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_sel  <= RESET_WAVE;
      gain_pct  <= RESET_GAIN;
      pitch_idx <= PITCH_RESET;
    end else if (accept) begin
      wave_sel  <= wave_next;
      gain_pct  <= gain_next;
      pitch_idx <= pitch_next;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // table data arrives with the stage; non-sample items carry a zero gain
  // so the product, and the sample, come out as zero
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_phase     <= req.payload.phase;
      s1_wave      <= wave_next;
      s1_gain      <= is_sample ? gain_pct : '0;
      s1_rpt.wave  <= wave_next;
      s1_rpt.vol   <= gain_next;
      s1_rpt.pitch <= pitch_next;
    end
  end

  assign sin_val = s1_phase[15] ? (SAMPLE_W'(0) - {1'b0, rom_rdata}) : {1'b0, rom_rdata};

  always_comb begin
    unique case (s1_wave)
      WAVE_SINE:   w_val = sin_val;
      WAVE_SQUARE: w_val = (s1_phase <= PHASE_HALF) ? SAMPLE_MIN : SAMPLE_MAX;
      WAVE_TRIANGLE: begin
        // rising edge, clipped peak, falling edge; 16-bit wrap is intended
        if (s1_phase < PHASE_HALF) begin
          w_val = (s1_phase - PHASE_QTR) << 1;
        end else if (s1_phase == PHASE_HALF) begin
          w_val = SAMPLE_MAX;
        end else begin
          w_val = (PHASE_3QTR - s1_phase) << 1;
        end
      end
      WAVE_SAW:    w_val = s1_phase ^ PHASE_HALF;
    endcase
  end

  assign prod_next = $signed({{(PROD_W-SAMPLE_W){w_val[SAMPLE_W-1]}}, w_val}) *
                     $signed({{(PROD_W-VOL_W){1'b0}}, s1_gain});

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_prod <= prod_next;
      s2_rpt  <= s1_rpt;
    end
  end

  // truncate toward zero: divide the magnitude, restore the sign afterwards
  assign pmag      = s2_prod[PROD_W-1] ? PMAG_W'(-s2_prod) : PMAG_W'(s2_prod);
  assign quot_full = {{PMAG_W{1'b0}}, pmag} * {{PMAG_W{1'b0}}, RECIP_100};

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_q   <= quot_full[RECIP_SHIFT +: SAMPLE_W];
      s3_neg <= s2_prod[PROD_W-1];
      s3_rpt <= s2_rpt;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rdy_o) begin
      o_item.sample     <= s3_neg ? $signed(SAMPLE_W'(0) - s3_q) : $signed(s3_q);
      o_item.wave_now   <= s3_rpt.wave;
      o_item.volume_now <= s3_rpt.vol;
      o_item.pitch_step <= s3_rpt.pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      o_vld <= 1'b0;
    end else begin
      if (rdy1)  v1    <= accept;
      if (rdy2)  v2    <= v1;
      if (rdy3)  v3    <= v2;
      if (rdy_o) o_vld <= v3;
    end
  end

  assign rsp.valid   = o_vld;
  assign rsp.payload = o_item;

  // ---------------------------------------------------------------- checks
  `MWO_CHECK(a_gain_range, gain_pct <= MAX_GAIN, "volume above full scale")
  `MWO_CHECK(a_pitch_range, pitch_idx <= PITCH_MAX, "pitch index beyond last step")
  `MWO_IMPLY(a_accept_after_fill, req.valid && req.ready, fill_stat.done, "item taken before table fill")
  `MWO_IMPLY(a_mute_zero, rsp.valid && rsp.payload.volume_now == '0, rsp.payload.sample == '0, "non-zero sample at zero volume")

endmodule

// ===== verif/multi_waveform_oscillator_sample_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for multi_waveform_oscillator_sample_core: directed table, then random runs.
// Depends on mwo_pkg, mwo_stream_if and the core RTL; nothing else is read.

module multi_waveform_oscillator_sample_core_test;
  import mwo_pkg::*;

  localparam int SINE_BITS   = 10;
  localparam int RAND_ITEMS  = 500;
  localparam int STALL_LIMIT = 3000;  // quiet cycles allowed; covers the table fill after rst
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int DIR_ROWS    = 26;

  // mode code with no meaning: must leave every setting alone
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [PHASE_W-1:0] phase;
    bit                 known;  // expected result typed in below
    out_t               res;
  } dir_row_t;

  logic clk;
  logic rst;

  mwo_stream_if #(.payload_t(in_t))  req_ch ();
  mwo_stream_if #(.payload_t(out_t)) rsp_ch ();

  multi_waveform_oscillator_sample_core #(
    .SINE_ADDR_BITS(SINE_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Side band that travels with each item: a typed-in expectation, if any.
  bit   hint_known;
  out_t hint_res;

  // Own copy of the oscillator settings and the sine table.
  logic [WAVE_W-1:0]  osc_wave;
  logic [VOL_W-1:0]   osc_gain;
  logic [PITCH_W-1:0] osc_pitch;
  logic [15:0]        sine_tab [1 << SINE_BITS];

  out_t pending_results [$];
  int   items_in;
  int   results_out;
  int   errors;
  int   wave_samples [4];
  int   clamp_hits;
  int   tx_idle_pct;
  int   rx_stall_pct;

  // Directed part; starts from reset (square, volume 10, pitch 24).
  dir_row_t dir_tab [DIR_ROWS] = '{
    // square: low half including the midpoint, then high half
    '{MODE_SAMPLE,     16'h0000, 1'b1, '{-3276, WAVE_SQUARE,   7'd10, 6'd24}},
    '{MODE_SAMPLE,     16'h8000, 1'b1, '{-3276, WAVE_SQUARE,   7'd10, 6'd24}},
    '{MODE_SAMPLE,     16'h8001, 1'b1, '{ 3276, WAVE_SQUARE,   7'd10, 6'd24}},
    '{MODE_SAMPLE,     16'hFFFF, 1'b1, '{ 3276, WAVE_SQUARE,   7'd10, 6'd24}},
    // unused mode: no change, sample zero
    '{MODE_UNUSED,     16'hFFFF, 1'b1, '{    0, WAVE_SQUARE,   7'd10, 6'd24}},
    '{MODE_WAVE_NEXT,  16'h0000, 1'b1, '{    0, WAVE_TRIANGLE, 7'd10, 6'd24}},
    // triangle peak saturates rather than wrapping
    '{MODE_SAMPLE,     16'h8000, 1'b1, '{ 3276, WAVE_TRIANGLE, 7'd10, 6'd24}},
    '{MODE_SAMPLE,     16'h0000, 1'b1, '{-3276, WAVE_TRIANGLE, 7'd10, 6'd24}},
    '{MODE_SAMPLE,     16'h4000, 1'b1, '{    0, WAVE_TRIANGLE, 7'd10, 6'd24}},
    '{MODE_SAMPLE,     16'h8001, 1'b1, '{ 3276, WAVE_TRIANGLE, 7'd10, 6'd24}},
    '{MODE_WAVE_NEXT,  16'h1234, 1'b1, '{    0, WAVE_SAW,      7'd10, 6'd24}},
    '{MODE_SAMPLE,     16'hFFFF, 1'b1, '{ 3276, WAVE_SAW,      7'd10, 6'd24}},
    // forward wrap to sine
    '{MODE_WAVE_NEXT,  16'h0000, 1'b1, '{    0, WAVE_SINE,     7'd10, 6'd24}},
    '{MODE_SAMPLE,     16'h4000, 1'b0, '0},
    '{MODE_SAMPLE,     16'hC000, 1'b0, '0},
    // backward wrap to sawtooth
    '{MODE_WAVE_PREV,  16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd10, 6'd24}},
    '{MODE_VOL_DOWN,   16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd8,  6'd24}},
    '{MODE_VOL_DOWN,   16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd6,  6'd24}},
    '{MODE_VOL_DOWN,   16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd4,  6'd24}},
    '{MODE_VOL_DOWN,   16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd2,  6'd24}},
    '{MODE_VOL_DOWN,   16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd0,  6'd24}},
    // volume clamps at zero, and a zero volume silences the sample
    '{MODE_VOL_DOWN,   16'hFFFF, 1'b1, '{    0, WAVE_SAW,      7'd0,  6'd24}},
    '{MODE_SAMPLE,     16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd0,  6'd24}},
    '{MODE_PITCH_DOWN, 16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd0,  6'd23}},
    '{MODE_PITCH_UP,   16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd0,  6'd24}},
    '{MODE_VOL_UP,     16'h0000, 1'b1, '{    0, WAVE_SAW,      7'd2,  6'd24}}
  };

  logic [PHASE_W-1:0] corner_phases [9] = '{
    16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000,
    16'h8001, 16'hBFFF, 16'hC000, 16'hFFFF
  };

  // 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Quarter-wave magnitude, Q16 polynomial, for r in 0..Q.
  function automatic longint unsigned quarter_wave(input longint unsigned r);
    longint unsigned x, x2, t, y;
    x  = r << (18 - SINE_BITS);
    x2 = (x * x) >> 16;
    t  = 64'd42048 - ((x2 * 64'd4640) >> 16);
    t  = 64'd102944 - ((x2 * t) >> 16);
    y  = (x * t) >> 16;
    return (y * 64'd32767 + 64'd32768) >> 16;
  endfunction

  // Works out the result of one item and moves the settings on.
  function automatic out_t osc_expect(input in_t it);
    out_t               res;
    int                 p;
    int                 s;
    logic signed [15:0] sine_val;
    p   = it.phase;
    s   = 0;
    res = '0;
    case (it.mode)
      MODE_SAMPLE: begin
        case (osc_wave)
          WAVE_SINE: begin
            sine_val = sine_tab[it.phase >> (16 - SINE_BITS)] ^ 16'h8000;
            s = sine_val;
          end
          WAVE_SQUARE: begin
            s = (p <= 32768) ? -32768 : 32767;
          end
          WAVE_TRIANGLE: begin
            if (p <= 32768) begin
              s = 2 * (p - 16384);
              if (s > 32767) s = 32767;
            end else begin
              s = -2 * (p - 49152);
            end
          end
          default: begin
            s = p - 32768;
          end
        endcase
        wave_samples[osc_wave]++;
        s = s * int'(osc_gain) / 100;  // truncates toward zero
      end
      MODE_WAVE_NEXT:  osc_wave = osc_wave + 2'd1;
      MODE_WAVE_PREV:  osc_wave = osc_wave - 2'd1;
      MODE_PITCH_UP: begin
        if (osc_pitch < PITCH_MAX) osc_pitch = osc_pitch + 6'd1;
        else clamp_hits++;
      end
      MODE_PITCH_DOWN: begin
        if (osc_pitch > 0) osc_pitch = osc_pitch - 6'd1;
        else clamp_hits++;
      end
      MODE_VOL_UP: begin
        if (int'(osc_gain) + int'(GAIN_STEP) > int'(MAX_GAIN)) begin
          if (osc_gain == MAX_GAIN) clamp_hits++;
          osc_gain = MAX_GAIN;
        end else begin
          osc_gain = osc_gain + GAIN_STEP;
        end
      end
      MODE_VOL_DOWN: begin
        if (osc_gain < GAIN_STEP) begin
          clamp_hits++;
          osc_gain = '0;
        end else begin
          osc_gain = osc_gain - GAIN_STEP;
        end
      end
      default: ;  // unused code
    endcase
    res.sample     = s;
    res.wave_now   = osc_wave;
    res.volume_now = osc_gain;
    res.pitch_step = osc_pitch;
    return res;
  endfunction

  task automatic report_bad(input string why, input out_t want, input out_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s: want sample %0d wave %0d vol %0d pitch %0d, got sample %0d wave %0d vol %0d pitch %0d",
               $realtime, why, want.sample, want.wave_now, want.volume_now, want.pitch_step,
               got.sample, got.wave_now, got.volume_now, got.pitch_step);
  endtask

  // Offers one item, with a random gap first, and returns once it is taken.
  task automatic send_item(input in_t it, input bit known, input out_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= it;
    hint_known     <= known;
    hint_res       <= res;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_in++;
  endtask

  // Holds off the sender until every item taken so far has its result back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_out != items_in);
  endtask

  // Receiver: random back-pressure at the current rate.
  always @(posedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(99) >= rx_stall_pct);
  end

  // Scoreboard: predict on every accepted item, check every accepted result.
  always @(posedge clk) begin
    out_t want;
    out_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        want = osc_expect(req_ch.payload);  // settings always move on
        if (hint_known) want = hint_res;
        pending_results.push_back(want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        results_out++;
        if (pending_results.size() == 0) begin
          report_bad("result with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.sample !== want.sample || got.wave_now !== want.wave_now ||
              got.volume_now !== want.volume_now || got.pitch_step !== want.pitch_step)
            report_bad("mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: too long with no item moving on either channel.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Sine table and reset settings, built once at time zero.
  initial begin
    int                q;
    longint unsigned   mag;
    logic [31:0]       ent;
    q = (1 << SINE_BITS) / 4;
    for (int i = 0; i < (1 << SINE_BITS); i++) begin
      mag = ((i / q) & 1) ? quarter_wave(q - (i % q)) : quarter_wave(i % q);
      ent = ((i / q) & 2) ? 32'h8000 - 32'(mag) : 32'h8000 + 32'(mag);
      sine_tab[i] = ent[15:0];
    end
    osc_wave  = RESET_WAVE;
    osc_gain  = RESET_GAIN;
    osc_pitch = PITCH_RESET;
  end

  // Stimulus.
  initial begin
    in_t                it;
    logic [MODE_W-1:0]  run_mode;
    int                 run_len;
    int                 kind;
    int                 n;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    hint_known     = 1'b0;
    hint_res       = '0;
    tx_idle_pct    = 21;
    rx_stall_pct   = 48;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table; req.ready stays low while the table RAM fills
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.mode  = dir_tab[i].mode;
      it.phase = dir_tab[i].phase;
      send_item(it, dir_tab[i].known, dir_tab[i].res);
    end
    drain_results();

    // random runs: mostly samples, step runs now and then long enough to hit the clamps
    n = 0;
    while (n < RAND_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        run_mode = MODE_SAMPLE;
        run_len  = $urandom_range(1, 12);
      end else if (kind < 88) begin
        run_mode = MODE_W'($urandom_range(MODE_WAVE_NEXT, MODE_VOL_DOWN));
        run_len  = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      end else if (kind < 93) begin
        run_mode = MODE_UNUSED;
        run_len  = 1;
      end else begin
        run_mode = MODE_W'($urandom_range(7));
        run_len  = 1;
      end
      for (int j = 0; j < run_len && n < RAND_ITEMS; j++) begin
        // swap the idling rates a third of the way in, then stop idling
        if (n == RAND_ITEMS / 3) begin
          drain_results();
          tx_idle_pct  = 48;
          rx_stall_pct = 21;
        end else if (n == 2 * RAND_ITEMS / 3) begin
          drain_results();
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        it.mode  = run_mode;
        it.phase = ($urandom_range(3) == 0) ? corner_phases[$urandom_range(8)]
                                            : PHASE_W'($urandom_range(65535));
        send_item(it, 1'b0, '0);
        n++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d items; samples by wave: sine %0d, square %0d, triangle %0d, saw %0d",
             items_in, wave_samples[WAVE_SINE], wave_samples[WAVE_SQUARE],
             wave_samples[WAVE_TRIANGLE], wave_samples[WAVE_SAW]);
    $display("%0d results checked, %0d clamped steps, %0d mismatches",
             results_out, clamp_hits, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
